// File: rtl/core/mhpq_pkg.sv
// Shared types, sizes and codes of the max-heap priority queue core.
// No dependencies; every other file of the core uses this package.
`default_nettype none

package mhpq_pkg;

   // Number of keys the queue holds
   localparam int CAPACITY = 16;
   // Width of the fill count, able to hold CAPACITY itself
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;

   // Command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_EMPTY      = 2'd2;

   typedef struct packed {
      logic                     command;
      logic signed [KEY_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]  removed_value;
      logic signed [KEY_W-1:0]  top_value;
      logic [4:0]               entry_count;
      logic [1:0]               status;
   } rsp_type;

   // Contents of one cell as seen by its neighbors
   typedef struct packed {
      logic                     valid;
      logic signed [KEY_W-1:0]  key;
   } cell_link_type;

   // Operation broadcast to every cell
   typedef struct packed {
      logic                     enable;
      logic                     remove;
      logic signed [KEY_W-1:0]  value;
   } cell_op_type;

endpackage

`default_nettype wire

// File: rtl/core/mhpq_cell.sv
// One cell of the sorted key chain: holds one key and its valid bit.
// Depends on mhpq_pkg for the link and operation structs.
`default_nettype none

module mhpq_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mhpq_pkg::cell_op_type   op,
   input  wire mhpq_pkg::cell_link_type left_link,
   input  wire logic                    left_gt,
   input  wire mhpq_pkg::cell_link_type right_link,
   output mhpq_pkg::cell_link_type      link,
   output logic                         gt
);

   logic                           valid_ff, valid_in;
   logic signed [mhpq_pkg::KEY_W-1:0] key_ff, key_in;

   // New key belongs at or above this cell
   assign gt = !valid_ff || (op.value > key_ff);

   // Pick next contents: shift toward the head on remove, open a gap on insert
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (op.enable) begin
         if (op.remove) begin
            valid_in = right_link.valid;
            key_in   = right_link.key;
         end else if (gt) begin
            if (left_gt) begin
               valid_in = left_link.valid;
               key_in   = left_link.key;
            end else begin
               valid_in = 1'b1;
               key_in   = op.value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign link.valid = valid_ff;
   assign link.key   = key_ff;

endmodule

`default_nettype wire

// File: rtl/core/max_heap_priority_queue_core.sv
// Top level of the max-heap priority queue core: command handling, fill count,
// result register and the chain of mhpq_cell key cells. Depends on mhpq_pkg and mhpq_cell.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one command per transfer:
//   insert a signed 32-bit key, or remove the maximum key.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one result per command:
//   the removed key, the maximum after the command, the entry count and a
//   status (done, insert refused full, remove refused empty).
//   Keys live in a chain of CAPACITY cells kept in descending order. Every
//   command that is not refused updates all cells together: on insert each
//   cell compares the new key with its own and keeps its own key, takes its
//   left neighbor's key or takes the new key; on remove each cell takes its
//   right neighbor's key. The result is registered in the cycle after the
//   command transfer. Throughput: one command per cycle while rsp_ready
//   stays high; the single cell update per command is what sets that figure.
//   Reset (synchronous, active high) empties the queue at once and drops any
//   pending result. While the receiver stalls, the result register holds and
//   req_ready stays low until the result is taken.
`default_nettype none

module max_heap_priority_queue_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mhpq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mhpq_pkg::rsp_type      rsp_data
);

   localparam int CAP = mhpq_pkg::CAPACITY;
   localparam int CW  = mhpq_pkg::COUNT_W;

   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  is_full, is_empty;
   mhpq_pkg::cell_op_type op;

   mhpq_pkg::cell_link_type links [CAP];
   logic                    gts   [CAP];

   // Take a command whenever the result slot is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_full  = (count_ff == CW'(CAP));
   assign is_empty = (count_ff == '0);

   // Broadcast the operation; refused commands leave the cells alone
   always_comb begin
      op.remove = (req_data.command == mhpq_pkg::CMD_REMOVE);
      op.value  = req_data.value;
      op.enable = accept && (op.remove ? !is_empty : !is_full);
   end

   // Chain of key cells, head holds the maximum
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      mhpq_pkg::cell_link_type left_link, right_link;
      logic                    left_gt;
      if (i == 0) begin : g_head
         assign left_link = '0;
         assign left_gt   = 1'b0;
      end else begin : g_mid
         assign left_link = links[i-1];
         assign left_gt   = gts[i-1];
      end
      if (i == CAP - 1) begin : g_tail
         assign right_link = '0;
      end else begin : g_body
         assign right_link = links[i+1];
      end
      mhpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .left_link  (left_link),
         .left_gt    (left_gt),
         .right_link (right_link),
         .link       (links[i]),
         .gt         (gts[i])
      );
   end

   // Next count and the result of the accepted command
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.removed_value = '0;
         rsp_data_in.status        = mhpq_pkg::STATUS_DONE;
         if (op.remove) begin
            if (is_empty) begin
               rsp_data_in.status    = mhpq_pkg::STATUS_EMPTY;
               rsp_data_in.top_value = '0;
            end else begin
               count_in                  = count_ff - CW'(1);
               rsp_data_in.removed_value = links[0].key;
               rsp_data_in.top_value     = (CAP > 1 && links[CAP > 1 ? 1 : 0].valid)
                                           ? links[CAP > 1 ? 1 : 0].key : '0;
            end
         end else begin
            if (is_full) begin
               rsp_data_in.status    = mhpq_pkg::STATUS_FULL;
               rsp_data_in.top_value = links[0].key;
            end else begin
               count_in              = count_ff + CW'(1);
               rsp_data_in.top_value = gts[0] ? op.value : links[0].key;
            end
         end
         rsp_data_in.entry_count = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
